// File: rtl/mpqu_pkg.sv
`default_nettype none
package mpqu_pkg;

  // queue geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int KEY_W    = 16;
  localparam int TAG_W    = 16;
  localparam int ENTRY_W  = KEY_W + TAG_W;
  localparam int OP_W     = 2;
  localparam int OCC_W    = 5;

  // request opcodes
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // memory port request from the controller
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // one result as driven on the output ports
  typedef struct packed {
    logic             strobe;
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             error;
    logic             full;
    logic             empty;
    logic [OCC_W-1:0] occ;
  } res_t;

  // low bits of the entry count as reported
  function automatic logic [OCC_W-1:0] occ_bits(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+OCC_W-1:0] wide;
    wide = {{OCC_W{1'b0}}, cnt};
    return wide[OCC_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/mpqu_ram.sv
`default_nettype none
module mpqu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/mpqu_ctrl.sv
`default_nettype none
module mpqu_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [mpqu_pkg::OP_W-1:0]  op,
  input  wire logic [mpqu_pkg::KEY_W-1:0] key,
  input  wire logic [mpqu_pkg::TAG_W-1:0] tag,
  input  wire mpqu_pkg::entry_t         rdata,
  output logic                          busy,
  output mpqu_pkg::mem_req_t            mem_req,
  output mpqu_pkg::res_t                res
);
  import mpqu_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  entry_t           best_r, best_nxt;
  logic [IDX_W-1:0] sh_r, sh_nxt;
  res_t             res_r, res_nxt;

  logic             accept;
  logic             take_new;
  entry_t           best_sel;
  logic [IDX_W-1:0] best_idx_sel;
  logic             last_cmp;
  logic             best_more;
  logic             sh_more;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign res    = res_r;

  // scan compare: strictly greater replaces, so the oldest of equal keys wins
  assign take_new     = (cmp_idx_r == '0) || (rdata.key > best_r.key);
  assign best_sel     = take_new ? rdata : best_r;
  assign best_idx_sel = take_new ? cmp_idx_r : best_idx_r;
  assign last_cmp     = (CNT_W'(cmp_idx_r) == CNT_W'(count_r - 1'b1));
  assign best_more    = ((CNT_W'(best_idx_sel) + CNT_W'(1)) < count_r);
  assign sh_more      = ((SUM_W'(sh_r) + SUM_W'(2)) < SUM_W'(count_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (op == OP_DEQUEUE || op == OP_PEEK) && count_r != '0) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_cmp) begin
          if (op_r == OP_DEQUEUE && best_more) begin
            state_nxt = ST_SHIFT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        if (!sh_more) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory requests, count and result
  always_comb begin
    mem_req      = '0;
    count_nxt    = count_r;
    op_nxt       = op_r;
    cmp_idx_nxt  = cmp_idx_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    sh_nxt       = sh_r;
    res_nxt      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt = op;
          unique case (op)
            OP_ENQUEUE: begin
              res_nxt.strobe = 1'b1;
              if (count_r == CNT_W'(CAPACITY)) begin
                res_nxt.error = 1'b1;
              end else begin
                mem_req.we        = 1'b1;
                mem_req.waddr     = count_r[IDX_W-1:0];
                mem_req.wdata.key = key;
                mem_req.wdata.tag = tag;
                count_nxt         = count_r + 1'b1;
              end
            end
            OP_DEQUEUE, OP_PEEK: begin
              if (count_r == '0) begin
                res_nxt.strobe = 1'b1;
                res_nxt.error  = 1'b1;
              end else begin
                mem_req.raddr = '0;
                cmp_idx_nxt   = '0;
              end
            end
            default: res_nxt.strobe = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        best_nxt      = best_sel;
        best_idx_nxt  = best_idx_sel;
        mem_req.raddr = cmp_idx_r + 1'b1;
        cmp_idx_nxt   = cmp_idx_r + 1'b1;
        if (last_cmp) begin
          if (op_r == OP_DEQUEUE && best_more) begin
            // start closing the gap: fetch the entry above the winner
            mem_req.raddr = best_idx_sel + 1'b1;
            sh_nxt        = best_idx_sel;
          end else begin
            res_nxt.strobe = 1'b1;
            res_nxt.valid  = 1'b1;
            res_nxt.key    = best_sel.key;
            res_nxt.tag    = best_sel.tag;
            if (op_r == OP_DEQUEUE) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
      end
      ST_SHIFT: begin
        // move entry sh+1 down to sh, prefetch sh+2
        mem_req.we    = 1'b1;
        mem_req.waddr = sh_r;
        mem_req.wdata = rdata;
        mem_req.raddr = IDX_W'(SUM_W'(sh_r) + SUM_W'(2));
        sh_nxt        = sh_r + 1'b1;
        if (!sh_more) begin
          count_nxt      = count_r - 1'b1;
          res_nxt.strobe = 1'b1;
          res_nxt.valid  = 1'b1;
          res_nxt.key    = best_r.key;
          res_nxt.tag    = best_r.tag;
        end
      end
      default: ;
    endcase
    res_nxt.full  = (count_nxt == CNT_W'(CAPACITY));
    res_nxt.empty = (count_nxt == '0);
    res_nxt.occ   = occ_bits(count_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      res_r   <= res_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    sh_r       <= sh_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(cmp_idx_r) < count_r))
    else $error("scan index beyond stored entries");

  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !(accept && op == OP_ENQUEUE)) |-> !mem_req.we)
    else $error("memory write while idle without an enqueue");

  a_valid_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.strobe |-> !(res_r.valid && res_r.error))
    else $error("result both valid and in error");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.strobe && res_r.valid && op_r == OP_DEQUEUE)
      |-> (SUM_W'(count_r) + SUM_W'(1) == SUM_W'($past(count_r))))
    else $error("dequeue did not remove exactly one entry");

endmodule
`default_nettype wire

// File: rtl/max_priority_queue_unsorted_core.sv
`default_nettype none
// Max-priority queue of mpqu_pkg::CAPACITY entries (key, tag) kept unsorted in a
// single-port-read, single-port-write entry memory. A request is taken when start
// is high and busy is low; its result is shown on the out_ ports for exactly one
// cycle with out_strobe high, the cycle after the request completes, and must be
// taken then since there is no way to hold it. Enqueue, any error case and the
// unused opcode complete in the accept cycle (busy stays low, one request per
// cycle). Peek and dequeue keep busy high while the memory read port scans the
// stored entries one entry per cycle; a dequeue then stays busy while the entries
// above the winner are moved down one per cycle. Among equal keys the oldest
// entry wins.
// No clearing pass after reset.
module max_priority_queue_unsorted_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [mpqu_pkg::OP_W-1:0]  in_op,
  input  wire logic [mpqu_pkg::KEY_W-1:0] in_entry_key,
  input  wire logic [mpqu_pkg::TAG_W-1:0] in_entry_tag,
  output logic                           out_strobe,
  output logic                           out_valid,
  output logic [mpqu_pkg::KEY_W-1:0]      out_key,
  output logic [mpqu_pkg::TAG_W-1:0]      out_tag,
  output logic                           out_error,
  output logic                           out_is_full,
  output logic                           out_is_empty,
  output logic [mpqu_pkg::OCC_W-1:0]      out_occupancy
);
  import mpqu_pkg::*;

  mem_req_t mem_req;
  entry_t   rdata;
  res_t     res;

  // entry memory
  mpqu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // sequencer, scan and count
  mpqu_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .op      (in_op),
    .key     (in_entry_key),
    .tag     (in_entry_tag),
    .rdata   (rdata),
    .busy    (busy),
    .mem_req (mem_req),
    .res     (res)
  );

  assign out_strobe    = res.strobe;
  assign out_valid     = res.valid;
  assign out_key       = res.key;
  assign out_tag       = res.tag;
  assign out_error     = res.error;
  assign out_is_full   = res.full;
  assign out_is_empty  = res.empty;
  assign out_occupancy = res.occ;

endmodule
`default_nettype wire
